@@ src/pbfs_pkg.sv @@
package pbfs_pkg;

	// Default sizes of the flag table and of one word bank.
	localparam int MAX_FLAGS_DEF  = 1024;
	localparam int BANK_DEPTH_DEF = 2048;

	// Configuration registers.
	localparam int NUM_CFG   = 3;
	localparam int CFG_W     = 12;
	localparam int CFG_RESET = 2048;

	// Field widths.
	localparam int WORD_W  = 32;
	localparam int POS_W   = 16;
	localparam int WIDTH_W = 6;

	typedef enum logic [1:0] {
		OP_DEFINE = 2'd0,
		OP_WRITE  = 2'd1,
		OP_READ   = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK     = 3'd0,
		ST_ABSENT = 3'd1,
		ST_TRUNC  = 3'd2,
		ST_WIDTH  = 3'd3,
		ST_OVER   = 3'd4
	} status_t;

	// One flag definition: bank, width and bit position.
	typedef struct packed {
		logic [1:0]         bank;
		logic [WIDTH_W-1:0] width;
		logic [POS_W-1:0]   pos;
	} entry_t;

	// Mask of the low w bits; 32 or more gives all ones.
	function automatic logic [WORD_W-1:0] low_mask(input logic [WIDTH_W-1:0] w);
		logic [WORD_W-1:0] m;
		if (w >= 6'd32) begin
			m = '1;
		end else begin
			m = (32'd1 << w) - 32'd1;
		end
		return m;
	endfunction

endpackage

@@ src/pbfs_spram.sv @@
module pbfs_spram #(
	parameter int W = 32,
	parameter int D = 16
) (
	input  logic                         clk,
	input  logic                         we,
	input  logic [(D > 1 ? $clog2(D) : 1)-1:0] addr,
	input  logic [W-1:0]                 wdata,
	output logic [W-1:0]                 rdata
);

	logic [W-1:0] mem [D];
	logic [W-1:0] rdata_q;

	// One access a cycle; the read data is registered.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;

endmodule

@@ src/packed_bitfield_flag_store_core.sv @@
// Packed flag store: flags of 1 to 32 bits live in three banks of 32-bit words held in one
// single-port memory, and their definitions in a second single-port memory. Each item is
// worked on alone by a sequencer around the word memory. In the dispatch state a define
// writes its definition and ends, as does a clear of an absent bank or a flag number out
// of range. A write or read next reads the definition and ends on an absent bank; else it
// reads the low word, then the high word of a field that straddles two words; a write then
// writes them back, two reads and two writes on the one port for such a field. A bank
// clear zeroes its bank's words in use. The input is free again as the result beat rises.
// After reset a clearing pass zeroes all 3*BANK_DEPTH words, one a cycle, before the first
// item is taken; configuration writes are taken at any time. A result beat still waiting on
// the output holds the finished item in its done state, so the input stalls until it leaves.
module packed_bitfield_flag_store_core #(
	parameter int MAX_FLAGS  = pbfs_pkg::MAX_FLAGS_DEF,
	parameter int BANK_DEPTH = pbfs_pkg::BANK_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [11:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  op,
	input  logic [9:0]  flag_number,
	input  logic [1:0]  bank_select,
	input  logic [5:0]  field_width,
	input  logic [31:0] write_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] read_value,
	output logic        is_nonzero,
	output logic [15:0] assigned_position,
	output logic [2:0]  status
);

	localparam int WORDS = 3 * BANK_DEPTH;
	localparam int WAW   = WORDS > 1 ? $clog2(WORDS) : 1;
	localparam int FAW   = MAX_FLAGS > 1 ? $clog2(MAX_FLAGS) : 1;

	typedef enum logic [8:0] {
		S_INIT = 9'b000000001,
		S_IDLE = 9'b000000010,
		S_DISP = 9'b000000100,
		S_ENT  = 9'b000001000,
		S_LO   = 9'b000010000,
		S_HI   = 9'b000100000,
		S_WR2  = 9'b001000000,
		S_CLR  = 9'b010000000,
		S_DONE = 9'b100000000
	} state_t;

	state_t state_q, state_d;

	logic [11:0]    cfg_q [3];
	logic [15:0]    np_q [3];
	logic [WAW-1:0] cnt_q;
	logic [11:0]    clr_q;
	logic           out_valid_q;

	// Item and work registers.
	logic [1:0]  op_q, bsel_q, bank_q;
	logic [9:0]  fn_q;
	logic [5:0]  reqw_q, w_q;
	logic [31:0] val_q, lo_q, hi_q;
	logic [4:0]  bp_q;
	logic [11:0] wi_q, size_q;
	logic        ok0_q;
	logic [31:0] res_rd_q, out_rd_q;
	logic [15:0] res_pos_q, out_pos_q;
	logic [2:0]  res_st_q, out_st_q;

	// Memory ports.
	logic           wm_we, fm_we;
	logic [WAW-1:0] wm_addr;
	logic [FAW-1:0] fm_addr;
	logic [31:0]    wm_wdata, wm_rdata;
	logic [23:0]    fm_wdata, fm_rdata;

	logic        res_ld;
	logic [31:0] res_rd;
	logic [15:0] res_pos;
	logic [2:0]  res_st;

	pbfs_spram #(.W(32), .D(WORDS)) u_words (
		.clk(clk), .we(wm_we), .addr(wm_addr), .wdata(wm_wdata), .rdata(wm_rdata)
	);

	pbfs_spram #(.W(24), .D(MAX_FLAGS)) u_flags (
		.clk(clk), .we(fm_we), .addr(fm_addr), .wdata(fm_wdata), .rdata(fm_rdata)
	);

	// Words in use in a bank, limited to the bank depth; bank zero has none.
	function automatic logic [11:0] bank_size(input logic [1:0] b);
		logic [11:0] n;
		n = '0;
		if (b != 2'd0) begin
			n = cfg_q[b - 2'd1];
			if (32'(n) > BANK_DEPTH) begin
				n = 12'(BANK_DEPTH);
			end
		end
		return n;
	endfunction

	function automatic logic [WAW-1:0] waddr(input logic [1:0] b, input logic [11:0] idx);
		return WAW'((32'(b) - 32'd1) * BANK_DEPTH + 32'(idx));
	endfunction

	// Define: clamp the width and place the flag at the bank's running position.
	logic [5:0]        def_w;
	logic              def_adj;
	logic [15:0]       def_pos, def_next;
	logic [16:0]       def_round;
	logic [11:0]       bsz;
	logic [2:0]        def_st;
	pbfs_pkg::entry_t  def_ent;

	always_comb begin
		def_adj = 1'b0;
		def_w   = reqw_q;
		if (reqw_q == 6'd0) begin
			def_w   = 6'd1;
			def_adj = 1'b1;
		end else if (reqw_q > 6'd32) begin
			def_w   = 6'd32;
			def_adj = 1'b1;
		end
		bsz       = bank_size(bsel_q);
		def_pos   = (bsel_q == 2'd0) ? 16'd0 : np_q[bsel_q - 2'd1];
		def_next  = def_pos + 16'(def_w);
		def_round = ({1'b0, def_next} + 17'd31) >> 5;
		if (bsel_q == 2'd0 || bsz == 12'd0) begin
			def_st = pbfs_pkg::ST_ABSENT;
		end else if (17'(bsz) <= def_round) begin
			def_st = pbfs_pkg::ST_OVER;
		end else if (def_adj) begin
			def_st = pbfs_pkg::ST_WIDTH;
		end else begin
			def_st = pbfs_pkg::ST_OK;
		end
		def_ent = '{bank: bsel_q, width: def_w, pos: def_pos};
	end

	// Decode of the stored definition.
	pbfs_pkg::entry_t ent;
	logic [5:0]       ent_w;
	logic [11:0]      ent_wi, ent_size;

	always_comb begin
		ent   = pbfs_pkg::entry_t'(fm_rdata);
		ent_w = ent.width;
		if (ent.width == 6'd0) begin
			ent_w = 6'd1;
		end else if (ent.width > 6'd32) begin
			ent_w = 6'd32;
		end
		ent_wi   = {1'b0, ent.pos[15:5]};
		ent_size = bank_size(ent.bank);
	end

	// Field merge and extraction.
	logic        straddle, ok1, trunc, over;
	logic [11:0] hi_idx;
	logic [31:0] mask_w, valm, lo_cur, hi_cur, lo_src, hi_term, lo_new, hi_new, rd_val;
	logic [6:0]  span;

	always_comb begin
		span     = 7'(w_q) + 7'(bp_q);
		straddle = span > 7'd32;
		hi_idx   = wi_q + 12'd1;
		ok1      = hi_idx < size_q;
		mask_w   = pbfs_pkg::low_mask(w_q);
		valm     = val_q & mask_w;
		trunc    = |(val_q & ~mask_w);
		lo_cur   = ok0_q ? wm_rdata : 32'd0;
		hi_cur   = ok1 ? wm_rdata : 32'd0;
		lo_src   = (state_q == S_LO) ? lo_cur : lo_q;
		hi_term  = (state_q == S_HI) ? hi_cur : 32'd0;
		lo_new   = (lo_src & ~(mask_w << bp_q)) | (valm << bp_q);
		hi_new   = (hi_cur & ~pbfs_pkg::low_mask(6'(span - 7'd32)))
			| (valm >> (6'd32 - 6'(bp_q)));
		rd_val   = ((lo_src >> bp_q)
			| ((bp_q == 5'd0) ? 32'd0 : (hi_term << (6'd32 - 6'(bp_q))))) & mask_w;
		over     = !ok0_q || (straddle && !ok1);
	end

	// Sequencer: next state, memory accesses and result.
	always_comb begin
		state_d  = state_q;
		wm_we    = 1'b0;
		wm_addr  = '0;
		wm_wdata = '0;
		fm_we    = 1'b0;
		fm_addr  = FAW'(fn_q);
		fm_wdata = def_ent;
		res_ld   = 1'b0;
		res_rd   = '0;
		res_pos  = '0;
		res_st   = pbfs_pkg::ST_OK;
		case (state_q)
			S_INIT: begin
				wm_we   = 1'b1;
				wm_addr = cnt_q;
				if (cnt_q == WAW'(WORDS - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				if (pbfs_pkg::op_t'(op_q) == pbfs_pkg::OP_CLEAR) begin
					if (bsz == 12'd0) begin
						res_ld  = 1'b1;
						res_st  = pbfs_pkg::ST_ABSENT;
						state_d = S_DONE;
					end else begin
						state_d = S_CLR;
					end
				end else if (32'(fn_q) >= MAX_FLAGS) begin
					res_ld  = 1'b1;
					res_st  = pbfs_pkg::ST_ABSENT;
					state_d = S_DONE;
				end else if (pbfs_pkg::op_t'(op_q) == pbfs_pkg::OP_DEFINE) begin
					fm_we   = 1'b1;
					res_ld  = 1'b1;
					res_pos = def_pos;
					res_st  = def_st;
					state_d = S_DONE;
				end else begin
					state_d = S_ENT;
				end
			end
			S_ENT: begin
				if (ent_size == 12'd0) begin
					res_ld  = 1'b1;
					res_st  = pbfs_pkg::ST_ABSENT;
					state_d = S_DONE;
				end else begin
					if (ent_wi < ent_size) begin
						wm_addr = waddr(ent.bank, ent_wi);
					end
					state_d = S_LO;
				end
			end
			S_LO: begin
				if (straddle) begin
					if (ok1) begin
						wm_addr = waddr(bank_q, hi_idx);
					end
					state_d = S_HI;
				end else begin
					res_ld  = 1'b1;
					state_d = S_DONE;
					if (pbfs_pkg::op_t'(op_q) == pbfs_pkg::OP_WRITE) begin
						wm_we    = ok0_q;
						wm_addr  = ok0_q ? waddr(bank_q, wi_q) : '0;
						wm_wdata = lo_new;
						res_st   = over ? pbfs_pkg::ST_OVER
							: (trunc ? pbfs_pkg::ST_TRUNC : pbfs_pkg::ST_OK);
					end else begin
						res_rd = rd_val;
						res_st = over ? pbfs_pkg::ST_OVER : pbfs_pkg::ST_OK;
					end
				end
			end
			S_HI: begin
				if (pbfs_pkg::op_t'(op_q) == pbfs_pkg::OP_WRITE) begin
					wm_we    = ok0_q;
					wm_addr  = ok0_q ? waddr(bank_q, wi_q) : '0;
					wm_wdata = lo_new;
					state_d  = S_WR2;
				end else begin
					res_ld  = 1'b1;
					res_rd  = rd_val;
					res_st  = over ? pbfs_pkg::ST_OVER : pbfs_pkg::ST_OK;
					state_d = S_DONE;
				end
			end
			S_WR2: begin
				wm_we    = ok1;
				wm_addr  = ok1 ? waddr(bank_q, hi_idx) : '0;
				wm_wdata = hi_q;
				res_ld   = 1'b1;
				res_st   = over ? pbfs_pkg::ST_OVER
					: (trunc ? pbfs_pkg::ST_TRUNC : pbfs_pkg::ST_OK);
				state_d  = S_DONE;
			end
			S_CLR: begin
				wm_we   = 1'b1;
				wm_addr = waddr(bsel_q, clr_q);
				if (clr_q == bsz - 12'd1) begin
					res_ld  = 1'b1;
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (!out_valid_q || !out_stall) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < pbfs_pkg::NUM_CFG; i++) begin
				cfg_q[i] <= 12'(pbfs_pkg::CFG_RESET);
				np_q[i]  <= '0;
			end
		end else begin
			state_q <= state_d;
			if (state_q == S_INIT) begin
				cnt_q <= cnt_q + WAW'(1);
			end
			if (cfg_we && 32'(cfg_index) < pbfs_pkg::NUM_CFG) begin
				cfg_q[cfg_index] <= cfg_data;
			end
			if (state_q == S_DISP && fm_we && bsel_q != 2'd0) begin
				np_q[bsel_q - 2'd1] <= def_next;
			end
			if (state_q == S_DONE && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload and work registers.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			op_q   <= op;
			fn_q   <= flag_number;
			bsel_q <= bank_select;
			reqw_q <= field_width;
			val_q  <= write_value;
		end
		if (state_q == S_DISP) begin
			clr_q <= '0;
		end else if (state_q == S_CLR) begin
			clr_q <= clr_q + 12'd1;
		end
		if (state_q == S_ENT) begin
			bank_q <= ent.bank;
			w_q    <= ent_w;
			bp_q   <= ent.pos[4:0];
			wi_q   <= ent_wi;
			size_q <= ent_size;
			ok0_q  <= ent_wi < ent_size;
		end
		if (state_q == S_LO) begin
			lo_q <= lo_cur;
		end
		if (state_q == S_HI) begin
			hi_q <= hi_new;
		end
		if (res_ld) begin
			res_rd_q  <= res_rd;
			res_pos_q <= res_pos;
			res_st_q  <= res_st;
		end
		if (state_q == S_DONE && (!out_valid_q || !out_stall)) begin
			out_rd_q  <= res_rd_q;
			out_pos_q <= res_pos_q;
			out_st_q  <= res_st_q;
		end
	end

	assign in_stall          = state_q != S_IDLE;
	assign out_valid         = out_valid_q;
	assign read_value        = out_rd_q;
	assign is_nonzero        = out_rd_q != 32'd0;
	assign assigned_position = out_pos_q;
	assign status            = out_st_q;

`ifndef SYNTHESIS
	// A result beat appears only when a finished item leaves its done state.
	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_DONE))
		else $error("result beat without a finished item");

	// The word memory is never written while the block waits for an item.
	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !wm_we)
		else $error("word memory written while idle");

	// An accepted item is dispatched in the next cycle.
	a_accept_disp: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> state_q == S_DISP)
		else $error("accepted item not dispatched");
`endif

endmodule

@@ tb/sv/pbfs_checker.sv @@
// Watches the item, result and configuration ports of the flag store, keeps its own
// copy of the flag definitions, bank words and position counters, and checks every
// result beat against the oldest predicted result.
module pbfs_checker
	import pbfs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [11:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [1:0]  op,
	input  logic [9:0]  flag_number,
	input  logic [1:0]  bank_select,
	input  logic [5:0]  field_width,
	input  logic [31:0] write_value,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [31:0] read_value,
	input  logic        is_nonzero,
	input  logic [15:0] assigned_position,
	input  logic [2:0]  status,
	output int          pending,
	output int          failures
);

	typedef struct packed {
		logic [31:0] value;
		logic        nonzero;
		logic [15:0] position;
		status_t     st;
	} flag_result_t;

	flag_result_t results_due[$];
	entry_t       flag_defs[0:MAX_FLAGS_DEF-1];
	logic [31:0]  words[0:3*BANK_DEPTH_DEF-1];
	logic [15:0]  next_pos[0:2];
	logic [11:0]  bank_cfg[0:2];

	// Words in use in a bank, with bank zero absent and large settings capped.
	function automatic int bank_size(input logic [1:0] b);
		int n;
		if (b == 2'd0) begin
			return 0;
		end
		n = bank_cfg[b - 1];
		return (n > BANK_DEPTH_DEF) ? BANK_DEPTH_DEF : n;
	endfunction

	function automatic bit word_fetch(input logic [1:0] b, input int idx,
			output logic [31:0] v);
		if (idx >= bank_size(b)) begin
			v = '0;
			return 1'b0;
		end
		v = words[(b - 1) * BANK_DEPTH_DEF + idx];
		return 1'b1;
	endfunction

	function automatic void word_store(input logic [1:0] b, input int idx,
			input logic [31:0] v);
		if (idx < bank_size(b)) begin
			words[(b - 1) * BANK_DEPTH_DEF + idx] = v;
		end
	endfunction

	// Applies one accepted item to the shadow state and returns its result.
	function automatic flag_result_t apply_item(input op_t o, input logic [9:0] fn,
			input logic [1:0] bs, input logic [5:0] fw, input logic [31:0] wv);
		flag_result_t r;
		entry_t       e;
		int           n, w, need, wi, bp;
		bit           adj, ok, ok1;
		logic [15:0]  pos;
		logic [31:0]  m, m2, val, w0, w1, lo, hi, hs;
		r = '0;
		r.st = ST_OK;
		case (o)
			OP_CLEAR: begin
				n = bank_size(bs);
				if (n == 0) begin
					r.st = ST_ABSENT;
				end else begin
					for (int i = 0; i < n; i++) begin
						words[(bs - 1) * BANK_DEPTH_DEF + i] = '0;
					end
				end
			end
			OP_DEFINE: begin
				w = fw;
				adj = 1'b0;
				if (w == 0) begin
					w = 1;
					adj = 1'b1;
				end else if (w > 32) begin
					w = 32;
					adj = 1'b1;
				end
				pos = '0;
				if (bs == 2'd0) begin
					r.st = ST_ABSENT;
				end else begin
					n = bank_size(bs);
					pos = next_pos[bs - 1];
					next_pos[bs - 1] = pos + 16'(w);
					need = (int'(next_pos[bs - 1]) + 31) >> 5;
					if (n == 0) begin
						r.st = ST_ABSENT;
					end else if (n <= need) begin
						r.st = ST_OVER;
					end else if (adj) begin
						r.st = ST_WIDTH;
					end
				end
				e.bank = bs;
				e.width = 6'(w);
				e.pos = pos;
				flag_defs[fn] = e;
				r.position = pos;
			end
			default: begin
				e = flag_defs[fn];
				w = e.width;
				if (w == 0) begin
					w = 1;
				end
				if (w > 32) begin
					w = 32;
				end
				wi = e.pos >> 5;
				bp = e.pos & 31;
				m = (w >= 32) ? '1 : ((32'd1 << w) - 32'd1);
				if (bank_size(e.bank) == 0) begin
					r.st = ST_ABSENT;
				end else if (o == OP_WRITE) begin
					val = wv;
					if ((val & ~m) != '0) begin
						val = val & m;
						r.st = ST_TRUNC;
					end
					ok = word_fetch(e.bank, wi, w0);
					if (w > 1) begin
						w0 = (w0 & ~(m << bp)) | (val << bp);
						if (ok) begin
							word_store(e.bank, wi, w0);
						end
						// A field that runs past bit 31 spills into the next word.
						if (w + bp > 32) begin
							m2 = (32'd1 << (w + bp - 32)) - 32'd1;
							if (word_fetch(e.bank, wi + 1, w1)) begin
								word_store(e.bank, wi + 1, (w1 & ~m2) | (val >> (32 - bp)));
							end else begin
								ok = 1'b0;
							end
						end
					end else if (ok) begin
						if (val == '0) begin
							w0 = w0 & ~(32'd1 << bp);
						end else begin
							w0 = w0 | (32'd1 << bp);
						end
						word_store(e.bank, wi, w0);
					end
					if (!ok) begin
						r.st = ST_OVER;
					end
				end else begin
					ok = word_fetch(e.bank, wi, lo);
					if (w > 1) begin
						ok1 = word_fetch(e.bank, wi + 1, hi);
						// The upper word contributes nothing when the field starts at bit 0.
						hs = (bp == 0) ? '0 : (hi << (32 - bp));
						if (w + bp > 32 && !ok1) begin
							ok = 1'b0;
						end
						r.value = ((lo >> bp) | hs) & m;
					end else begin
						r.value = (lo >> bp) & 32'd1;
					end
					if (!ok) begin
						r.st = ST_OVER;
					end
				end
			end
		endcase
		r.nonzero = (r.value != '0);
		return r;
	endfunction

	// Compare result beats, follow configuration writes, predict item beats.
	always @(posedge clk or negedge arst_n) begin
		flag_result_t want;
		if (!arst_n) begin
			for (int i = 0; i < 3 * BANK_DEPTH_DEF; i++) begin
				words[i] = '0;
			end
			for (int i = 0; i < MAX_FLAGS_DEF; i++) begin
				flag_defs[i] = '0;
			end
			for (int i = 0; i < 3; i++) begin
				next_pos[i] = '0;
				bank_cfg[i] = 12'(CFG_RESET);
			end
			results_due.delete();
			pending <= 0;
			failures <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (results_due.size() == 0) begin
					failures <= failures + 1;
					if (failures < 10) begin
						$display("result beat with nothing expected: value %h status %0d",
							read_value, status);
					end
				end else begin
					want = results_due.pop_front();
					if (read_value !== want.value || is_nonzero !== want.nonzero ||
							assigned_position !== want.position || status !== want.st) begin
						failures <= failures + 1;
						if (failures < 10) begin
							$display("mismatch: expected value %h nz %b pos %0d status %0d",
								want.value, want.nonzero, want.position, want.st);
							$display("          actual   value %h nz %b pos %0d status %0d",
								read_value, is_nonzero, assigned_position, status);
						end
					end
				end
			end
			if (cfg_we && cfg_index < 2'd3) begin
				bank_cfg[cfg_index] = cfg_data;
			end
			if (in_valid && !in_stall) begin
				results_due.push_back(apply_item(op_t'(op), flag_number, bank_select,
					field_width, write_value));
			end
			pending <= results_due.size();
		end
	end

endmodule

@@ tb/sv/tb_packed_bitfield_flag_store_core.sv @@
module tb_packed_bitfield_flag_store_core;
	import pbfs_pkg::*;

	typedef enum logic [1:0] {
		REG_BANK_ONE   = 2'd0,
		REG_BANK_TWO   = 2'd1,
		REG_BANK_THREE = 2'd2
	} cfg_reg_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [11:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  op = '0;
	logic [9:0]  flag_number = '0;
	logic [1:0]  bank_select = '0;
	logic [5:0]  field_width = '0;
	logic [31:0] write_value = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] read_value;
	logic        is_nonzero;
	logic [15:0] assigned_position;
	logic [2:0]  status;
	int          pending;
	int          failures;

	// Flags that have been defined at least once; only these are written or read.
	bit          is_defined[0:MAX_FLAGS_DEF-1];
	logic [9:0]  defined_flags[$];
	int          burst_left = 0;

	packed_bitfield_flag_store_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.op(op), .flag_number(flag_number), .bank_select(bank_select),
		.field_width(field_width), .write_value(write_value),
		.out_valid(out_valid), .out_stall(out_stall),
		.read_value(read_value), .is_nonzero(is_nonzero),
		.assigned_position(assigned_position), .status(status)
	);

	pbfs_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.op(op), .flag_number(flag_number), .bank_select(bank_select),
		.field_width(field_width), .write_value(write_value),
		.out_valid(out_valid), .out_stall(out_stall),
		.read_value(read_value), .is_nonzero(is_nonzero),
		.assigned_position(assigned_position), .status(status),
		.pending(pending), .failures(failures)
	);

	always #10 clk = ~clk;

	// Run limit, far beyond the slowest correct run.
	initial begin
		#(20 * 2000000);
		$display("tb_packed_bitfield_flag_store_core: errors");
		$finish;
	end

	// Receiver stall pattern, with one long hold-off so the block backs up.
	initial begin : stall_gen
		int span;
		int mode;
		int cycle_count;
		bit held;
		cycle_count = 0;
		held = 1'b0;
		forever begin
			span = $urandom_range(20, 200);
			mode = $urandom_range(0, 2);
			if (!held && cycle_count >= 7000) begin
				held = 1'b1;
				mode = 3;
				span = 600;
			end
			repeat (span) begin
				@(posedge clk);
				cycle_count++;
				case (mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 9) < 3);
					2: out_stall <= ($urandom_range(0, 9) < 7);
					default: out_stall <= 1'b1;
				endcase
			end
		end
	end

	// Offers one item beat, opening a new burst with a random gap when one runs out.
	task automatic send_beat(input op_t o, input logic [9:0] fn, input logic [1:0] bs,
			input logic [5:0] fw, input logic [31:0] wv);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 30);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		op <= o;
		flag_number <= fn;
		bank_select <= bs;
		field_width <= fw;
		write_value <= wv;
		do @(posedge clk); while (in_stall);
		if (o == OP_DEFINE && !is_defined[fn]) begin
			is_defined[fn] = 1'b1;
			defined_flags.push_back(fn);
		end
	endtask

	// Drops valid and waits until every predicted result has come back.
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic set_banks(input logic [11:0] one, input logic [11:0] two,
			input logic [11:0] three);
		cfg_we <= 1'b1;
		cfg_index <= REG_BANK_ONE;
		cfg_data <= one;
		@(posedge clk);
		cfg_index <= REG_BANK_TWO;
		cfg_data <= two;
		@(posedge clk);
		cfg_index <= REG_BANK_THREE;
		cfg_data <= three;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Random item: mostly defines, writes and reads of defined flags, rare clears.
	task automatic random_item();
		int pick;
		logic [9:0] fn;
		logic [5:0] fw;
		logic [31:0] wv;
		pick = $urandom_range(0, 99);
		fw = ($urandom_range(0, 9) < 7) ? 6'($urandom_range(1, 32)) : 6'($urandom_range(0, 63));
		wv = ($urandom_range(0, 1) == 0) ? $urandom : ($urandom >> $urandom_range(0, 31));
		if (pick < 2) begin
			send_beat(OP_CLEAR, 10'($urandom), 2'($urandom_range(0, 3)), fw, wv);
		end else if (pick < 30 || defined_flags.size() == 0) begin
			send_beat(OP_DEFINE, 10'($urandom_range(0, 1023)),
				($urandom_range(0, 9) == 0) ? 2'd0 : 2'($urandom_range(1, 3)), fw, wv);
		end else begin
			fn = defined_flags[$urandom_range(0, defined_flags.size() - 1)];
			send_beat((pick < 65) ? OP_WRITE : OP_READ, fn, 2'($urandom), fw, wv);
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: width clamps, bank zero, straddling fields, truncation, clears.
		send_beat(OP_DEFINE, 10'd0, 2'd1, 6'd0, 32'd0);
		send_beat(OP_DEFINE, 10'd1023, 2'd2, 6'd63, 32'd0);
		send_beat(OP_DEFINE, 10'd5, 2'd1, 6'd31, 32'd0);
		send_beat(OP_DEFINE, 10'd7, 2'd1, 6'd20, 32'd0);
		send_beat(OP_DEFINE, 10'd8, 2'd1, 6'd30, 32'd0);
		send_beat(OP_DEFINE, 10'd3, 2'd0, 6'd8, 32'd0);
		send_beat(OP_DEFINE, 10'd9, 2'd3, 6'd1, 32'd0);
		send_beat(OP_WRITE, 10'd0, 2'd0, 6'd0, 32'd1);
		send_beat(OP_READ, 10'd0, 2'd0, 6'd0, 32'd0);
		send_beat(OP_WRITE, 10'd0, 2'd0, 6'd0, 32'd2);
		send_beat(OP_WRITE, 10'd1023, 2'd0, 6'd0, 32'hFFFF_FFFF);
		send_beat(OP_WRITE, 10'd8, 2'd0, 6'd0, 32'h3FFF_FFFF);
		send_beat(OP_READ, 10'd8, 2'd0, 6'd0, 32'd0);
		send_beat(OP_WRITE, 10'd8, 2'd0, 6'd0, 32'hFFFF_FFFF);
		send_beat(OP_WRITE, 10'd7, 2'd0, 6'd0, 32'h000A_BCDE);
		send_beat(OP_WRITE, 10'd3, 2'd0, 6'd0, 32'h55);
		send_beat(OP_READ, 10'd0, 2'd0, 6'd0, 32'd0);
		send_beat(OP_READ, 10'd1023, 2'd0, 6'd0, 32'd0);
		send_beat(OP_READ, 10'd7, 2'd0, 6'd0, 32'd0);
		send_beat(OP_READ, 10'd3, 2'd0, 6'd0, 32'd0);
		send_beat(OP_READ, 10'd9, 2'd0, 6'd0, 32'd0);
		send_beat(OP_CLEAR, 10'd0, 2'd0, 6'd0, 32'd0);
		send_beat(OP_CLEAR, 10'd0, 2'd1, 6'd0, 32'd0);
		send_beat(OP_READ, 10'd8, 2'd0, 6'd0, 32'd0);

		// Random phases, each under its own bank sizes, extremes among them.
		for (int phase = 0; phase < 5; phase++) begin
			drain();
			case (phase)
				0: set_banks(12'd2048, 12'd2048, 12'd2048);
				1: set_banks(12'd3, 12'd4095, 12'd0);
				2: set_banks(12'd0, 12'd1, 12'd100);
				3: set_banks(12'd2048, 12'd17, 12'd2048);
				default: set_banks(12'd4095, 12'd2048, 12'd1);
			endcase
			repeat (400) random_item();
		end

		drain();
		repeat (20) @(posedge clk);
		if (failures == 0) begin
			$display("tb_packed_bitfield_flag_store_core: clean");
		end else begin
			$display("tb_packed_bitfield_flag_store_core: errors");
		end
		$finish;
	end

endmodule
